>>> rtl/element_integral_accumulator_core_macros.svh
// assertion macros of the element integral accumulator checker
`ifndef ELEMENT_INTEGRAL_ACCUMULATOR_CORE_MACROS_SVH
`define ELEMENT_INTEGRAL_ACCUMULATOR_CORE_MACROS_SVH

// same-cycle implication, off while in reset
`define EIA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("element integral accumulator: assertion failed");

// next-cycle implication, off while in reset
`define EIA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("element integral accumulator: assertion failed");

// next-cycle implication, also checked during reset
`define EIA_ASSERT_NXT_ALL(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("element integral accumulator: assertion failed");

`endif

>>> rtl/eia_pkg.sv
// shared types, constants and helpers of the element integral accumulator
package eia_pkg;

    localparam int MAX_NODES_DEF = 8;
    localparam int MAX_FACES_DEF = 6;

    localparam int DW      = 32;            // q16.16 operand
    localparam int WW      = 31;            // point weight
    localparam int AW      = 64;            // accumulator
    localparam int FRAC    = 16;
    localparam int PAIR_K  = 5;
    localparam int NODE_K  = 4;
    localparam int LANE_K  = 5;
    localparam int PT_W    = 4 * DW;
    localparam int PROD_W  = 2 * DW - FRAC;
    localparam int LANE_W  = PROD_W + 2;    // sum of three products
    localparam int LO_W    = 25;
    localparam int HI_W    = LANE_W - LO_W;
    localparam int FULL_W  = HI_W + WW + 1 + LO_W;
    localparam int SH_W    = FULL_W - FRAC;

    localparam int OFF_REGION = 0;
    localparam int OFF_NODE   = 3;
    localparam int OFF_COL    = 6;
    localparam int OFF_VAL    = 9;
    localparam int OFF_GX     = OFF_VAL + DW;
    localparam int OFF_GY     = OFF_GX + DW;
    localparam int OFF_GZ     = OFF_GY + DW;
    localparam int OFF_W      = OFF_GZ + DW;
    localparam int S_TDATA_W  = OFF_W + WW;
    localparam int M_TDATA_W  = AW * (PAIR_K + NODE_K);

    typedef enum logic [1:0] {
        REQ_LOAD  = 2'd0,
        REQ_READ  = 2'd1,
        REQ_CLEAR = 2'd2
    } t_req;

    typedef enum logic [3:0] {
        ST_CLR, ST_IDLE, ST_RDOUT, ST_IROW, ST_ILAT, ST_JRD,
        ST_MUL1, ST_SUM, ST_NRD, ST_MUL2, ST_FIN, ST_WB
    } t_state;

    typedef struct packed {
        logic ld_row;
        logic ld_prod;
        logic ld_lane;
        logic node_pass;
        logic ld_part;
        logic ld_term;
    } t_arith_ctl;

    typedef struct packed {
        logic pair_re;
        logic pair_we;
        logic node_re;
        logic node_we;
    } t_mem_ctl;

    function automatic logic [AW-1:0] sat_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {a[AW-1], a} + {b[AW-1], b};
        if (s[AW] != s[AW-1]) begin
            sat_add = s[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
        end else begin
            sat_add = s[AW-1:0];
        end
    endfunction

endpackage

>>> rtl/eia_ptbuf.sv
// point buffer memory: shape value and gradient of each node
module eia_ptbuf import eia_pkg::*; #(
    parameter int MAX_NODES = MAX_NODES_DEF,
    localparam int NW = $clog2(MAX_NODES)
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [NW-1:0]   i_waddr,
    input  logic [PT_W-1:0] i_wdata,
    input  logic            i_re,
    input  logic [NW-1:0]   i_raddr,
    output logic [PT_W-1:0] o_rdata
);

    logic [PT_W-1:0] r_mem [MAX_NODES];
    logic [PT_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/eia_accmem.sv
// accumulator memories: pair rows and node rows, one row per entry set
module eia_accmem import eia_pkg::*; #(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int MAX_FACES = MAX_FACES_DEF,
    localparam int PAIR_ROWS = (1 + MAX_FACES) * MAX_NODES * MAX_NODES,
    localparam int NODE_ROWS = (1 + MAX_FACES) * MAX_NODES,
    localparam int PAW = $clog2(PAIR_ROWS),
    localparam int NAW = $clog2(NODE_ROWS)
) (
    input  logic                 i_clk,
    input  t_mem_ctl             i_ctl,
    input  logic [PAW-1:0]       i_pair_waddr,
    input  logic [PAW-1:0]       i_pair_raddr,
    input  logic [PAIR_K*AW-1:0] i_pair_wdata,
    output logic [PAIR_K*AW-1:0] o_pair_rdata,
    input  logic [NAW-1:0]       i_node_waddr,
    input  logic [NAW-1:0]       i_node_raddr,
    input  logic [NODE_K*AW-1:0] i_node_wdata,
    output logic [NODE_K*AW-1:0] o_node_rdata
);

    logic [PAIR_K*AW-1:0] r_pair_mem [PAIR_ROWS];
    logic [NODE_K*AW-1:0] r_node_mem [NODE_ROWS];
    logic [PAIR_K*AW-1:0] r_pair_rdata;
    logic [NODE_K*AW-1:0] r_node_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.pair_we) begin
            r_pair_mem[i_pair_waddr] <= i_pair_wdata;
        end
        if (i_ctl.pair_re) begin
            r_pair_rdata <= r_pair_mem[i_pair_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.node_we) begin
            r_node_mem[i_node_waddr] <= i_node_wdata;
        end
        if (i_ctl.node_re) begin
            r_node_rdata <= r_node_mem[i_node_raddr];
        end
    end

    assign o_pair_rdata = r_pair_rdata;
    assign o_node_rdata = r_node_rdata;

endmodule

>>> rtl/eia_arith.sv
// product datapath: q16.16 products, dot sum, weight products with saturation
module eia_arith import eia_pkg::*; (
    input  logic                 i_clk,
    input  t_arith_ctl           i_ctl,
    input  logic [PT_W-1:0]      i_pt,
    input  logic [WW-1:0]        i_weight,
    output logic [LANE_K*AW-1:0] o_term
);

    logic signed [DW-1:0]       r_vi;
    logic signed [DW-1:0]       r_gi [3];
    logic signed [PROD_W-1:0]   r_prod [7];
    logic signed [LANE_W-1:0]   r_lane [LANE_K];
    logic [LO_W+WW-1:0]         r_lo [LANE_K];
    logic signed [HI_W+WW:0]    r_hi [LANE_K];
    logic [AW-1:0]              r_term [LANE_K];

    logic signed [DW-1:0]       c_vj;
    logic signed [DW-1:0]       c_gj [3];
    logic signed [2*DW-1:0]     c_full_gg [3];
    logic signed [2*DW-1:0]     c_full_vg [3];
    logic signed [2*DW-1:0]     c_full_vv;
    logic signed [LANE_W-1:0]   c_dot;
    logic signed [LANE_W-1:0]   c_lane [LANE_K];
    logic [LO_W+WW-1:0]         c_lo [LANE_K];
    logic signed [HI_W+WW:0]    c_hi [LANE_K];
    logic [FULL_W-1:0]          c_p [LANE_K];
    logic [SH_W-1:0]            c_s [LANE_K];
    logic [AW-1:0]              c_term [LANE_K];

    always_comb begin
        c_vj    = i_pt[0 +: DW];
        c_gj[0] = i_pt[DW +: DW];
        c_gj[1] = i_pt[2*DW +: DW];
        c_gj[2] = i_pt[3*DW +: DW];
        for (int c = 0; c < 3; c++) begin
            c_full_gg[c] = r_gi[c] * c_gj[c];
            c_full_vg[c] = r_vi * c_gj[c];
        end
        c_full_vv = r_vi * c_vj;
        c_dot = LANE_W'(r_prod[0]) + LANE_W'(r_prod[1]) + LANE_W'(r_prod[2]);
        if (i_ctl.node_pass) begin
            c_lane[0] = LANE_W'(r_vi);
            c_lane[1] = LANE_W'(r_gi[0]);
            c_lane[2] = LANE_W'(r_gi[1]);
            c_lane[3] = LANE_W'(r_gi[2]);
            c_lane[4] = '0;
        end else begin
            c_lane[0] = c_dot;
            c_lane[1] = LANE_W'(r_prod[3]);
            c_lane[2] = LANE_W'(r_prod[4]);
            c_lane[3] = LANE_W'(r_prod[5]);
            c_lane[4] = LANE_W'(r_prod[6]);
        end
        for (int k = 0; k < LANE_K; k++) begin
            c_lo[k] = r_lane[k][LO_W-1:0] * i_weight;
            c_hi[k] = $signed(r_lane[k][LANE_W-1:LO_W]) * $signed({1'b0, i_weight});
            // exact product, then floor shift and clamp to 64 bits
            c_p[k] = {r_hi[k], {LO_W{1'b0}}} + {{(FULL_W-LO_W-WW){1'b0}}, r_lo[k]};
            c_s[k] = c_p[k][FULL_W-1:FRAC];
            if ((&c_s[k][SH_W-1:AW-1]) || !(|c_s[k][SH_W-1:AW-1])) begin
                c_term[k] = c_s[k][AW-1:0];
            end else if (c_s[k][SH_W-1]) begin
                c_term[k] = {1'b1, {(AW-1){1'b0}}};
            end else begin
                c_term[k] = {1'b0, {(AW-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_row) begin
            r_vi    <= c_vj;
            r_gi[0] <= c_gj[0];
            r_gi[1] <= c_gj[1];
            r_gi[2] <= c_gj[2];
        end
        if (i_ctl.ld_prod) begin
            for (int c = 0; c < 3; c++) begin
                r_prod[c]     <= c_full_gg[c][2*DW-1:FRAC];
                r_prod[3 + c] <= c_full_vg[c][2*DW-1:FRAC];
            end
            r_prod[6] <= c_full_vv[2*DW-1:FRAC];
        end
        for (int k = 0; k < LANE_K; k++) begin
            if (i_ctl.ld_lane) begin
                r_lane[k] <= c_lane[k];
            end
            if (i_ctl.ld_part) begin
                r_lo[k] <= c_lo[k];
                r_hi[k] <= c_hi[k];
            end
            if (i_ctl.ld_term) begin
                r_term[k] <= c_term[k];
            end
        end
    end

    always_comb begin
        for (int k = 0; k < LANE_K; k++) begin
            o_term[k*AW +: AW] = r_term[k];
        end
    end

endmodule

>>> rtl/element_integral_accumulator_core.sv
// element integral accumulator top level: request sequencer and accumulator update
// load request: node written to the point buffer; a load with point end runs the
// read-modify-write walk over node pairs, one pair row of the memory at a time;
// read request: memory read registered, then result loaded into the output register;
// clear: zeroes the (1+MAX_FACES)*MAX_NODES^2 pair rows, 448 by default; also at reset
module element_integral_accumulator_core import eia_pkg::*; #(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int MAX_FACES = MAX_FACES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // region, node, col_node, shape_value, grad_x, grad_y, grad_z, point_weight
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    // req_type
    input  logic [1:0]           i_s_tuser,
    input  logic                 i_s_tlast,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // grad_grad, shape_grad_x, shape_grad_y, shape_grad_z, shape_shape,
    // shape_sum, grad_sum_x, grad_sum_y, grad_sum_z
    output logic [M_TDATA_W-1:0] o_m_tdata,
    input  logic                 i_cfg_we,
    input  logic [3:0]           i_cfg_wdata
);

    localparam int NW        = $clog2(MAX_NODES);
    localparam int PAIR_ROWS = (1 + MAX_FACES) * MAX_NODES * MAX_NODES;
    localparam int NODE_ROWS = (1 + MAX_FACES) * MAX_NODES;
    localparam int PAW       = $clog2(PAIR_ROWS);
    localparam int NAW       = $clog2(NODE_ROWS);

    t_state                r_state, n_state;
    logic [3:0]            r_node_count;
    logic [WW-1:0]         r_weight;
    logic [2:0]            r_region;
    logic                  r_vol;
    logic [NW-1:0]         r_i, r_j, r_last;
    logic                  r_npass;
    logic [PAW-1:0]        r_clr;
    logic                  r_rd_zero, r_rd_vol;
    logic                  r_out_valid;
    logic [M_TDATA_W-1:0]  r_out_data;

    logic                  s_acc;
    t_req                  s_req;
    logic [2:0]            s_region, s_node, s_col;
    logic [NW-1:0]         c_last;
    int                    c_n;

    t_mem_ctl              mctl;
    t_arith_ctl            actl;
    logic [PAW-1:0]        pair_waddr, pair_raddr, upd_pair_addr;
    logic [NAW-1:0]        node_waddr, node_raddr, upd_node_addr;
    logic [PAIR_K*AW-1:0]  pair_wdata, pair_rdata, pair_new;
    logic [NODE_K*AW-1:0]  node_wdata, node_rdata, node_new;
    logic                  pt_we, pt_re;
    logic [NW-1:0]         pt_raddr;
    logic [PT_W-1:0]       pt_rdata;
    logic [LANE_K*AW-1:0]  term;
    logic                  out_load;
    logic [M_TDATA_W-1:0]  c_out;

    assign o_s_tready = (r_state == ST_IDLE);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign s_req      = t_req'(i_s_tuser);
    assign s_region   = i_s_tdata[OFF_REGION +: 3];
    assign s_node     = i_s_tdata[OFF_NODE +: 3];
    assign s_col      = i_s_tdata[OFF_COL +: 3];

    always_comb begin
        c_n = int'(r_node_count);
        if (c_n < 1) begin
            c_n = 1;
        end
        if (c_n > MAX_NODES) begin
            c_n = MAX_NODES;
        end
        c_last = NW'(c_n - 1);
    end

    assign upd_pair_addr = PAW'((int'(r_region) * MAX_NODES + int'(r_i)) * MAX_NODES
                                + int'(r_j));
    assign upd_node_addr = NAW'(int'(r_region) * MAX_NODES + int'(r_i));

    assign pt_we = s_acc && (s_req == REQ_LOAD) && (int'(s_node) < MAX_NODES);

    // face regions never touch gradient-gradient or gradient sums
    always_comb begin
        for (int k = 0; k < PAIR_K; k++) begin
            pair_new[k*AW +: AW] = (k == 0 && !r_vol) ? pair_rdata[k*AW +: AW]
                : sat_add(pair_rdata[k*AW +: AW], term[k*AW +: AW]);
        end
        for (int k = 0; k < NODE_K; k++) begin
            node_new[k*AW +: AW] = (k != 0 && !r_vol) ? node_rdata[k*AW +: AW]
                : sat_add(node_rdata[k*AW +: AW], term[k*AW +: AW]);
        end
    end

    always_comb begin
        n_state    = r_state;
        mctl       = '0;
        actl       = '0;
        pt_re      = 1'b0;
        pt_raddr   = r_i;
        pair_waddr = upd_pair_addr;
        pair_raddr = upd_pair_addr;
        pair_wdata = pair_new;
        node_waddr = upd_node_addr;
        node_raddr = upd_node_addr;
        node_wdata = node_new;
        unique case (r_state)
            ST_CLR: begin
                mctl.pair_we = 1'b1;
                pair_waddr   = r_clr;
                pair_wdata   = '0;
                mctl.node_we = (int'(r_clr) < NODE_ROWS);
                node_waddr   = NAW'(r_clr);
                node_wdata   = '0;
                if (r_clr == PAW'(PAIR_ROWS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_acc) begin
                    unique case (s_req)
                        REQ_LOAD: begin
                            if (i_s_tlast && int'(s_region) <= MAX_FACES) begin
                                n_state = ST_IROW;
                            end
                        end
                        REQ_READ: begin
                            mctl.pair_re = 1'b1;
                            mctl.node_re = 1'b1;
                            pair_raddr   = PAW'((int'(s_region) * MAX_NODES + int'(s_node))
                                                * MAX_NODES + int'(s_col));
                            node_raddr   = NAW'(int'(s_region) * MAX_NODES + int'(s_node));
                            n_state      = ST_RDOUT;
                        end
                        REQ_CLEAR: begin
                            n_state = ST_CLR;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RDOUT: begin
                if (!r_out_valid || i_m_tready) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IROW: begin
                pt_re    = 1'b1;
                pt_raddr = r_i;
                n_state  = ST_ILAT;
            end
            ST_ILAT: begin
                actl.ld_row = 1'b1;
                n_state     = ST_JRD;
            end
            ST_JRD: begin
                pt_re        = 1'b1;
                pt_raddr     = r_j;
                mctl.pair_re = 1'b1;
                n_state      = ST_MUL1;
            end
            ST_MUL1: begin
                actl.ld_prod = 1'b1;
                n_state      = ST_SUM;
            end
            ST_SUM: begin
                actl.ld_lane = 1'b1;
                n_state      = ST_MUL2;
            end
            ST_NRD: begin
                mctl.node_re   = 1'b1;
                actl.ld_lane   = 1'b1;
                actl.node_pass = 1'b1;
                n_state        = ST_MUL2;
            end
            ST_MUL2: begin
                actl.ld_part = 1'b1;
                n_state      = ST_FIN;
            end
            ST_FIN: begin
                actl.ld_term = 1'b1;
                n_state      = ST_WB;
            end
            ST_WB: begin
                if (r_npass) begin
                    mctl.node_we = 1'b1;
                    n_state = (r_i == r_last) ? ST_IDLE : ST_IROW;
                end else begin
                    mctl.pair_we = 1'b1;
                    n_state = (r_j == r_last) ? ST_NRD : ST_JRD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign out_load = (r_state == ST_RDOUT) && (!r_out_valid || i_m_tready);

    always_comb begin
        c_out = {node_rdata, pair_rdata};
        if (!r_rd_vol) begin
            c_out[0 +: AW] = '0;
            c_out[(PAIR_K+1)*AW +: 3*AW] = '0;
        end
        if (r_rd_zero) begin
            c_out = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLR;
            r_clr        <= '0;
            r_out_valid  <= 1'b0;
            r_node_count <= 4'd8;
            r_weight     <= '0;
            r_npass      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_node_count <= i_cfg_wdata;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_CLR: begin
                    r_clr <= r_clr + 1'b1;
                end
                ST_IDLE: begin
                    if (s_acc && s_req == REQ_LOAD) begin
                        r_weight <= i_s_tdata[OFF_W +: WW];
                    end
                    if (s_acc && s_req == REQ_CLEAR) begin
                        r_clr <= '0;
                    end
                end
                ST_JRD: begin
                    r_npass <= 1'b0;
                end
                ST_NRD: begin
                    r_npass <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_region  <= s_region;
            r_vol     <= (s_region == 3'd0);
            r_i       <= '0;
            r_last    <= c_last;
            r_rd_vol  <= (s_region == 3'd0);
            r_rd_zero <= (int'(s_region) > MAX_FACES) || (int'(s_node) >= MAX_NODES)
                         || (int'(s_col) >= MAX_NODES);
        end
        if (r_state == ST_IROW) begin
            r_j <= '0;
        end
        if (r_state == ST_WB) begin
            if (r_npass) begin
                r_i <= r_i + 1'b1;
            end else begin
                r_j <= r_j + 1'b1;
            end
        end
        if (out_load) begin
            r_out_data <= c_out;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    eia_ptbuf #(.MAX_NODES(MAX_NODES)) u_ptbuf (
        .i_clk   (i_clk),
        .i_we    (pt_we),
        .i_waddr (NW'(s_node)),
        .i_wdata (i_s_tdata[OFF_VAL +: PT_W]),
        .i_re    (pt_re),
        .i_raddr (pt_raddr),
        .o_rdata (pt_rdata)
    );

    eia_accmem #(.MAX_NODES(MAX_NODES), .MAX_FACES(MAX_FACES)) u_accmem (
        .i_clk        (i_clk),
        .i_ctl        (mctl),
        .i_pair_waddr (pair_waddr),
        .i_pair_raddr (pair_raddr),
        .i_pair_wdata (pair_wdata),
        .o_pair_rdata (pair_rdata),
        .i_node_waddr (node_waddr),
        .i_node_raddr (node_raddr),
        .i_node_wdata (node_wdata),
        .o_node_rdata (node_rdata)
    );

    eia_arith u_arith (
        .i_clk    (i_clk),
        .i_ctl    (actl),
        .i_pt     (pt_rdata),
        .i_weight (r_weight),
        .o_term   (term)
    );

endmodule

>>> rtl/eia_checker.sv
// port-level checker of the element integral accumulator, bound to the top level
`include "element_integral_accumulator_core_macros.svh"

module eia_checker import eia_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_tvalid,
    input logic       o_s_tready,
    input logic [1:0] i_s_tuser,
    input logic       o_m_tvalid,
    input logic       i_m_tready
);

    logic s_acc;
    logic s_busy_acc;
    logic s_rd_acc;

    assign s_acc      = i_s_tvalid && o_s_tready;
    assign s_busy_acc = s_acc && (i_s_tuser == REQ_READ || i_s_tuser == REQ_CLEAR);
    assign s_rd_acc   = s_acc && (i_s_tuser == REQ_READ);

    `EIA_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid)
    `EIA_ASSERT_NXT_ALL(a_rst_busy, i_clk, !i_rst_n, !o_s_tready)
    `EIA_ASSERT_NXT(a_cmd_busy, i_clk, i_rst_n, s_busy_acc, !o_s_tready)
    `EIA_ASSERT_NXT(a_read_result, i_clk, i_rst_n, s_rd_acc && !o_m_tvalid, ##1 o_m_tvalid)
    `EIA_ASSERT_IMP(a_result_src, i_clk, i_rst_n, $rose(o_m_tvalid), $past(!o_s_tready))

endmodule

bind element_integral_accumulator_core eia_checker u_eia_checker (.*);

>>> tb/sv/element_integral_accumulator_core_tb.sv
// self-checking stream testbench of the element integral accumulator core
module element_integral_accumulator_core_tb;
    import eia_pkg::*;

    localparam logic [1:0] REQ_NONE = 2'd3;   // unused request code, ignored by the block
    localparam int NFACE_RGN = 7;             // volume plus six faces
    localparam int SETTLE = 500;              // longer than one point-end walk
    localparam int HOLD_CYCLES = 400;
    localparam logic signed [127:0] I64_MAX = 128'sh7fffffffffffffff;
    localparam logic signed [127:0] I64_MIN = -128'sh7fffffffffffffff - 1;

    typedef struct {
        logic [1:0]         req;
        logic [2:0]         rgn;
        logic [2:0]         node;
        logic [2:0]         col;
        logic signed [31:0] val;
        logic signed [31:0] gx;
        logic signed [31:0] gy;
        logic signed [31:0] gz;
        logic [30:0]        wgt;
        logic               last;
    } node_req_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_s_tvalid;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata;
    logic [1:0]           i_s_tuser;
    logic                 i_s_tlast;
    logic                 o_m_tvalid;
    logic                 i_m_tready;
    logic [M_TDATA_W-1:0] o_m_tdata;
    logic                 i_cfg_we;
    logic [3:0]           i_cfg_wdata;

    element_integral_accumulator_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // predicted state of the block
    logic signed [31:0] shape_buf [8];
    logic signed [31:0] grad_buf [8][3];
    logic [30:0]        weight_q;
    longint             pair_acc [NFACE_RGN][8][8][PAIR_K];
    longint             node_acc [NFACE_RGN][8][NODE_K];
    logic [3:0]         node_cfg;

    logic [M_TDATA_W-1:0] entry_q [$];
    int  mismatches;
    int  sent;
    bit  calm;
    bit  hold_req;
    string field_names [9] = '{"grad_grad", "shape_grad_x", "shape_grad_y", "shape_grad_z",
        "shape_shape", "shape_sum", "grad_sum_x", "grad_sum_y", "grad_sum_z"};

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    initial begin
        #40000000;
        $display("FAILURE");
        $finish;
    end

    // product shifted down by 16 with floor, saturated to 64 bits
    function automatic longint mul_q16(input longint x, input longint y);
        logic signed [127:0] a, b, p;
        a = x;
        b = y;
        p = (a * b) >>> FRAC;
        if (p > I64_MAX) return I64_MAX[63:0];
        if (p < I64_MIN) return I64_MIN[63:0];
        return p[63:0];
    endfunction

    function automatic longint acc_add(input longint a, input longint b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s[64] != s[63]) return s[64] ? I64_MIN[63:0] : I64_MAX[63:0];
        return s[63:0];
    endfunction

    function automatic void accumulate_point(input int r);
        int n;
        longint w, vi, dot;
        n = (node_cfg == 0) ? 1 : (node_cfg > 8) ? 8 : node_cfg;
        w = weight_q;
        for (int i = 0; i < n; i++) begin
            vi = shape_buf[i];
            for (int j = 0; j < n; j++) begin
                if (r == 0) begin
                    dot = 0;
                    for (int c = 0; c < 3; c++)
                        dot += mul_q16(grad_buf[i][c], grad_buf[j][c]);
                    pair_acc[r][i][j][0] = acc_add(pair_acc[r][i][j][0], mul_q16(dot, w));
                end
                for (int c = 0; c < 3; c++)
                    pair_acc[r][i][j][1+c] = acc_add(pair_acc[r][i][j][1+c],
                        mul_q16(mul_q16(vi, grad_buf[j][c]), w));
                pair_acc[r][i][j][4] = acc_add(pair_acc[r][i][j][4],
                    mul_q16(mul_q16(vi, shape_buf[j]), w));
            end
            node_acc[r][i][0] = acc_add(node_acc[r][i][0], mul_q16(vi, w));
            if (r == 0)
                for (int c = 0; c < 3; c++)
                    node_acc[r][i][1+c] = acc_add(node_acc[r][i][1+c], mul_q16(grad_buf[i][c], w));
        end
    endfunction

    function automatic void clear_accumulators();
        foreach (pair_acc[a, b, c, d]) pair_acc[a][b][c][d] = 0;
        foreach (node_acc[a, b, c]) node_acc[a][b][c] = 0;
    endfunction

    function automatic void predict(input node_req_t it);
        logic [M_TDATA_W-1:0] e;
        case (it.req)
            REQ_LOAD: begin
                shape_buf[it.node] = it.val;
                grad_buf[it.node][0] = it.gx;
                grad_buf[it.node][1] = it.gy;
                grad_buf[it.node][2] = it.gz;
                weight_q = it.wgt;
                if (it.last && it.rgn < NFACE_RGN) accumulate_point(it.rgn);
            end
            REQ_READ: begin
                e = '0;
                if (it.rgn < NFACE_RGN) begin
                    for (int k = 0; k < PAIR_K; k++)
                        e[AW*k +: AW] = pair_acc[it.rgn][it.node][it.col][k];
                    for (int k = 0; k < NODE_K; k++)
                        e[AW*(PAIR_K+k) +: AW] = node_acc[it.rgn][it.node][k];
                    // faces carry no gradient-gradient or gradient sums
                    if (it.rgn != 0) begin
                        e[0 +: AW] = '0;
                        e[AW*(PAIR_K+1) +: 3*AW] = '0;
                    end
                end
                entry_q = {entry_q, e};
            end
            REQ_CLEAR: clear_accumulators();
            default: ;
        endcase
    endfunction

    task automatic send(input node_req_t it);
        if (!calm && $urandom_range(0, 5) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= it.req;
        i_s_tlast  <= it.last;
        i_s_tdata  <= {it.wgt, it.gz, it.gy, it.gx, it.val, it.col, it.node, it.rgn};
        do @(posedge i_clk); while (!o_s_tready);
        predict(it);
        sent++;
    endtask

    // stop offering and let every result and any point-end walk finish
    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (entry_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_nodes(input logic [3:0] n);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= n;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        node_cfg = n;
    endtask

    function automatic logic [31:0] rand_q16();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
            default: return $urandom_range(0, 1 << 19) - (1 << 18);
        endcase
    endfunction

    function automatic logic [30:0] rand_weight();
        case ($urandom_range(0, 9))
            0: return 31'($urandom);
            1: return $urandom_range(0, 1) ? 31'h7fff_ffff : 31'h0;
            default: return 31'($urandom_range(0, 1 << 17));
        endcase
    endfunction

    function automatic node_req_t make_load(input int rgn, input int node, input bit last);
        node_req_t it;
        it.req = REQ_LOAD;
        it.rgn = 3'(rgn);
        it.node = 3'(node);
        it.col = 3'($urandom);
        it.val = rand_q16();
        it.gx = rand_q16();
        it.gy = rand_q16();
        it.gz = rand_q16();
        it.wgt = rand_weight();
        it.last = last;
        return it;
    endfunction

    function automatic node_req_t make_req(input logic [1:0] req, input int rgn,
                                           input int node, input int col);
        node_req_t it;
        it = make_load(rgn, node, $urandom_range(0, 1));
        it.req = req;
        it.col = 3'(col);
        return it;
    endfunction

    // one quadrature point: every node in random order, point end on the last
    task automatic send_point(input int rgn);
        int order [8];
        foreach (order[k]) order[k] = k;
        order.shuffle();
        foreach (order[k]) send(make_load(rgn, order[k], k == 7));
    endtask

    task automatic test_directed();
        node_req_t it;
        // first point fills every node buffer, with field extremes
        for (int k = 0; k < 8; k++) begin
            it = make_load(0, k, k == 7);
            if (k == 0) begin
                it.val = 32'h7fff_ffff; it.gx = 32'h7fff_ffff;
                it.gy = 32'h8000_0000; it.gz = 32'h8000_0000; it.wgt = 31'h7fff_ffff;
            end
            if (k == 1) begin
                it.val = '0; it.gx = '0; it.gy = 32'hffff_ffff; it.gz = 32'h0001_0000;
            end
            send(it);
        end
        send(make_req(REQ_READ, 0, 0, 0));
        send(make_req(REQ_READ, 0, 7, 1));
        send_point(1);
        send_point(6);
        send(make_load(7, 2, 1'b1));          // region out of range updates no accumulator
        send(make_req(REQ_READ, 1, 3, 4));
        send(make_req(REQ_READ, 6, 7, 7));
        send(make_req(REQ_READ, 7, 1, 2));
        send(make_req(REQ_NONE, 0, 0, 0));
        send(make_req(REQ_CLEAR, 0, 0, 0));
        send(make_req(REQ_READ, 0, 0, 0));
    endtask

    task automatic test_node_counts();
        logic [3:0] sweep [6] = '{4'd1, 4'd0, 4'd15, 4'd3, 4'd9, 4'd8};
        foreach (sweep[s]) begin
            set_nodes(sweep[s]);
            send_point($urandom_range(0, 6));
            send_point(0);
            repeat (4) send(make_req(REQ_READ, $urandom_range(0, 6), $urandom, $urandom));
        end
    endtask

    // output held off while reads keep coming, so the input side must stall
    task automatic test_backpressure();
        hold_req = 1'b1;
        repeat (30) send(make_req(REQ_READ, $urandom_range(0, 7), $urandom, $urandom));
    endtask

    task automatic test_random(input int count);
        int stop_at;
        stop_at = sent + count;
        while (sent < stop_at) begin
            case ($urandom_range(0, 19))
                0: send(make_load($urandom_range(0, 7), $urandom, $urandom_range(0, 1)));
                1: send(make_req(REQ_CLEAR, $urandom, $urandom, $urandom));
                2: send(make_req(REQ_NONE, $urandom, $urandom, $urandom));
                3, 4, 5, 6, 7, 8:
                    send(make_req(REQ_READ, ($urandom_range(0, 9) == 0) ? 7 : $urandom_range(0, 6),
                                  $urandom, $urandom));
                default: send_point(($urandom_range(0, 19) == 0) ? 7 : $urandom_range(0, 6));
            endcase
        end
    endtask

    task automatic test_sender_pause();
        drain();
        repeat (5) send(make_req(REQ_READ, 0, $urandom, $urandom));
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tuser = '0;
        i_s_tlast = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        mismatches = 0;
        sent = 0;
        calm = 1'b0;
        hold_req = 1'b0;
        weight_q = '0;
        node_cfg = 4'd8;
        foreach (shape_buf[k]) shape_buf[k] = '0;
        foreach (grad_buf[k, c]) grad_buf[k][c] = '0;
        clear_accumulators();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_node_counts();
        test_backpressure();
        test_sender_pause();
        set_nodes(4'd2);
        test_random(300);
        set_nodes(4'd8);
        test_random(650);
        calm = 1'b1;
        test_random(120);

        drain();
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // result receiver: random stall bursts, one long hold on request
    initial begin
        i_m_tready = 1'b1;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
                i_m_tready <= 1'b1;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
                i_m_tready <= 1'b1;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // compare each result against the oldest expected entry set
    initial begin
        logic [M_TDATA_W-1:0] e;
        bit bad;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) begin
                if (entry_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %h", o_m_tdata);
                end else begin
                    e = entry_q.pop_front();
                    bad = 1'b0;
                    for (int k = 0; k < 9; k++) begin
                        if (o_m_tdata[AW*k +: AW] !== e[AW*k +: AW]) begin
                            bad = 1'b1;
                            if (mismatches < 10)
                                $display("%s: expected %h, got %h", field_names[k],
                                         e[AW*k +: AW], o_m_tdata[AW*k +: AW]);
                        end
                    end
                    if (bad) mismatches++;
                end
            end
        end
    end

endmodule
